FILE: hw/rtl/bba_pkg.sv
// Shared types, command codes and saturation helper for the bounding box accumulator.
`timescale 1ns / 1ps

package bba_pkg;

  // Width of a stored box corner.
  localparam int CW = 32;
  // Width of the grow sums: wide enough for a 32-bit point plus a 34-bit half extent.
  localparam int SUM_W = (CW > 35) ? CW : 35;
  // Width of the extent difference before it is clamped to 64 bits.
  localparam int DIFF_W = 65;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_POINT  = 3'd1;
  localparam logic [2:0] CMD_SPHERE = 3'd2;
  localparam logic [2:0] CMD_DISK   = 3'd3;
  localparam logic [2:0] CMD_MERGE  = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Largest and smallest CW-bit coordinate, held in SUM_W bits.
  localparam logic signed [SUM_W-1:0] COORD_MAX = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_MIN = ~COORD_MAX;

  typedef struct packed {
    logic       upd_en;
    logic       clear;
    logic       grow;
    logic       box_valid;
    logic [2:0] cmd;
  } lane_ctrl_t;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > COORD_MAX) begin
      c = COORD_MAX;
    end else if (v < COORD_MIN) begin
      c = COORD_MIN;
    end else begin
      c = v;
    end
    return c[CW-1:0];
  endfunction

endpackage

FILE: hw/rtl/bba_lane.sv
// One axis lane: disk half extent, new extent, saturation and running min/max for that axis.
`timescale 1ns / 1ps

module bba_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_load,
  input  logic                          mul_en,
  input  bba_pkg::lane_ctrl_t           ctrl,
  input  logic signed [31:0]            in_p,
  input  logic signed [31:0]            in_om,
  input  logic [30:0]                   in_radius,
  input  logic signed [15:0]            in_n,
  output logic signed [bba_pkg::CW-1:0] low,
  output logic signed [bba_pkg::CW-1:0] high
);

  logic signed [31:0]            p_r;
  logic signed [31:0]            om_r;
  logic [30:0]                   r_r;
  logic [30:0]                   nsq_r;
  logic [61:0]                   prod_r;
  logic signed [bba_pkg::CW-1:0] low_r;
  logic signed [bba_pkg::CW-1:0] high_r;

  logic signed [31:0]            nsq_full;
  logic signed [32:0]            one_minus;
  logic [30:0]                   abs_d;
  logic [61:0]                   rounded;
  logic [33:0]                   half;
  logic signed [bba_pkg::SUM_W-1:0] p_ext;
  logic signed [bba_pkg::SUM_W-1:0] om_ext;
  logic signed [bba_pkg::SUM_W-1:0] off_ext;
  logic signed [bba_pkg::SUM_W-1:0] lo_sum;
  logic signed [bba_pkg::SUM_W-1:0] hi_sum;
  logic signed [bba_pkg::CW-1:0]    lo_sat;
  logic signed [bba_pkg::CW-1:0]    hi_sat;

  assign nsq_full = in_n * in_n;

  // |1 - n^2| in Q4.28; at most 3 * 2^28 so 31 bits hold it
  always_comb begin
    one_minus = 33'sd268435456 - $signed({2'b00, nsq_r});
    if (one_minus < 0) begin
      abs_d = 31'(-one_minus);
    end else begin
      abs_d = one_minus[30:0];
    end
  end

  assign rounded = prod_r + 62'd134217728;
  assign half    = rounded[61:28];

  always_comb begin
    p_ext  = bba_pkg::SUM_W'(p_r);
    om_ext = bba_pkg::SUM_W'(om_r);
    off_ext = '0;
    lo_sum  = p_ext;
    hi_sum  = p_ext;
    case (ctrl.cmd)
      bba_pkg::CMD_SPHERE: begin
        off_ext = $signed(bba_pkg::SUM_W'(r_r));
        lo_sum  = p_ext - off_ext;
        hi_sum  = p_ext + off_ext;
      end
      bba_pkg::CMD_DISK: begin
        off_ext = $signed(bba_pkg::SUM_W'(half));
        lo_sum  = p_ext - off_ext;
        hi_sum  = p_ext + off_ext;
      end
      bba_pkg::CMD_MERGE: begin
        hi_sum = om_ext;
      end
      default: begin
      end
    endcase
    lo_sat = bba_pkg::sat_coord(lo_sum);
    hi_sat = bba_pkg::sat_coord(hi_sum);
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      p_r   <= in_p;
      om_r  <= in_om;
      r_r   <= in_radius;
      nsq_r <= nsq_full[30:0];
    end
    if (mul_en) begin
      prod_r <= r_r * abs_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
    end else if (ctrl.upd_en) begin
      if (ctrl.clear) begin
        low_r  <= '0;
        high_r <= '0;
      end else if (ctrl.grow) begin
        if (!ctrl.box_valid || lo_sat < low_r) begin
          low_r <= lo_sat;
        end
        if (!ctrl.box_valid || hi_sat > high_r) begin
          high_r <= hi_sat;
        end
      end
    end
  end

  assign low  = low_r;
  assign high = high_r;

endmodule

FILE: hw/rtl/bba_merge.sv
// Merging stage: per-axis extents from the three lanes and longest/shortest axis selection.
`timescale 1ns / 1ps

module bba_merge (
  input  logic                          clk,
  input  logic                          ext_en,
  input  logic signed [bba_pkg::CW-1:0] low  [3],
  input  logic signed [bba_pkg::CW-1:0] high [3],
  output logic [1:0]                    longest_axis,
  output logic [1:0]                    shortest_axis
);

  localparam logic signed [bba_pkg::DIFF_W-1:0] D_MAX = {2'b00, {63{1'b1}}};
  localparam logic signed [bba_pkg::DIFF_W-1:0] D_MIN = ~D_MAX;

  logic signed [bba_pkg::DIFF_W-1:0] diff  [3];
  logic signed [63:0]                 ext_r [3];
  logic signed [63:0]                 d0;
  logic signed [63:0]                 d1;
  logic signed [63:0]                 d2;

  // extents clamped to the signed 64-bit range
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = $signed(bba_pkg::DIFF_W'(high[a])) - $signed(bba_pkg::DIFF_W'(low[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (ext_en) begin
      for (int a = 0; a < 3; a++) begin
        if (diff[a] > D_MAX) begin
          ext_r[a] <= D_MAX[63:0];
        end else if (diff[a] < D_MIN) begin
          ext_r[a] <= D_MIN[63:0];
        end else begin
          ext_r[a] <= diff[a][63:0];
        end
      end
    end
  end

  assign d0 = ext_r[0];
  assign d1 = ext_r[1];
  assign d2 = ext_r[2];

  // ties fall toward the later axis
  always_comb begin
    if (d0 > d1) begin
      longest_axis = (d0 > d2) ? bba_pkg::AXIS_X : ((d1 > d2) ? bba_pkg::AXIS_Y : bba_pkg::AXIS_Z);
    end else begin
      longest_axis = (d1 > d2) ? bba_pkg::AXIS_Y : bba_pkg::AXIS_Z;
    end
    if (d0 < d1) begin
      shortest_axis = (d0 < d2) ? bba_pkg::AXIS_X : ((d1 < d2) ? bba_pkg::AXIS_Y : bba_pkg::AXIS_Z);
    end else begin
      shortest_axis = (d1 < d2) ? bba_pkg::AXIS_Y : bba_pkg::AXIS_Z;
    end
  end

endmodule

FILE: hw/rtl/bounding_box_accumulator.sv
// Top level: command sequencer, three axis lanes, merging stage and output register.
// After the input transfer the item runs through the multiply, update, extent and result steps.
// A new item is taken only once the previous one has left the result step; the next item is taken while a result waits.
// The sequencer runs one item at a time through the multiply and update steps that all three lanes run together.
// Reset (rst_n low, synchronous): box cleared to zero corners and marked invalid,
// sequencer idle, no result pending.
`timescale 1ns / 1ps

module bounding_box_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [31:0] in_pz,
  input  logic [30:0]        in_radius,
  input  logic signed [15:0] in_nx,
  input  logic signed [15:0] in_ny,
  input  logic signed [15:0] in_nz,
  input  logic signed [31:0] in_other_max_x,
  input  logic signed [31:0] in_other_max_y,
  input  logic signed [31:0] in_other_max_z,
  input  logic               in_other_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_box_min_x,
  output logic signed [31:0] out_box_min_y,
  output logic signed [31:0] out_box_min_z,
  output logic signed [31:0] out_box_max_x,
  output logic signed [31:0] out_box_max_y,
  output logic signed [31:0] out_box_max_z,
  output logic               out_box_valid,
  output logic [1:0]         out_longest_axis,
  output logic [1:0]         out_shortest_axis
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_EXT  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  logic [2:0] cmd_r;
  logic       other_valid_r;
  logic       box_valid_r;
  logic       out_valid_r;

  logic signed [31:0] min_x_r, min_y_r, min_z_r;
  logic signed [31:0] max_x_r, max_y_r, max_z_r;
  logic               out_box_valid_r;
  logic [1:0]         longest_r;
  logic [1:0]         shortest_r;

  logic                 accept;
  logic                 res_load;
  logic                 grow;
  bba_pkg::lane_ctrl_t  ctrl;

  logic signed [31:0]            p_a   [3];
  logic signed [31:0]            om_a  [3];
  logic signed [15:0]            n_a   [3];
  logic signed [bba_pkg::CW-1:0] low_a [3];
  logic signed [bba_pkg::CW-1:0] high_a[3];
  logic [1:0]                    longest;
  logic [1:0]                    shortest;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign res_load = (state_r == ST_RES) && (!out_valid_r || out_ready);

  assign p_a[0]  = in_px;
  assign p_a[1]  = in_py;
  assign p_a[2]  = in_pz;
  assign om_a[0] = in_other_max_x;
  assign om_a[1] = in_other_max_y;
  assign om_a[2] = in_other_max_z;
  assign n_a[0]  = in_nx;
  assign n_a[1]  = in_ny;
  assign n_a[2]  = in_nz;

  always_comb begin
    case (cmd_r) inside
      bba_pkg::CMD_POINT, bba_pkg::CMD_SPHERE, bba_pkg::CMD_DISK: grow = 1'b1;
      bba_pkg::CMD_MERGE: grow = other_valid_r;
      default:            grow = 1'b0;
    endcase
  end

  assign ctrl.upd_en    = (state_r == ST_UPD);
  assign ctrl.clear     = (cmd_r == bba_pkg::CMD_CLEAR);
  assign ctrl.grow      = grow;
  assign ctrl.box_valid = box_valid_r;
  assign ctrl.cmd       = cmd_r;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    bba_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_load   (accept),
      .mul_en    (state_r == ST_MUL),
      .ctrl      (ctrl),
      .in_p      (p_a[a]),
      .in_om     (om_a[a]),
      .in_radius (in_radius),
      .in_n      (n_a[a]),
      .low       (low_a[a]),
      .high      (high_a[a])
    );
  end

  bba_merge u_merge (
    .clk           (clk),
    .ext_en        (state_r == ST_EXT),
    .low           (low_a),
    .high          (high_a),
    .longest_axis  (longest),
    .shortest_axis (shortest)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_EXT;
      ST_EXT:  state_nxt = ST_RES;
      ST_RES:  if (res_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      box_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctrl.upd_en) begin
        if (ctrl.clear) begin
          box_valid_r <= 1'b0;
        end else if (grow) begin
          box_valid_r <= 1'b1;
        end
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sign-extend the corners so narrower coordinates still give their low 32 bits
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r         <= in_command;
      other_valid_r <= in_other_valid;
    end
    if (res_load) begin
      min_x_r         <= 32'(bba_pkg::SUM_W'(low_a[0]));
      min_y_r         <= 32'(bba_pkg::SUM_W'(low_a[1]));
      min_z_r         <= 32'(bba_pkg::SUM_W'(low_a[2]));
      max_x_r         <= 32'(bba_pkg::SUM_W'(high_a[0]));
      max_y_r         <= 32'(bba_pkg::SUM_W'(high_a[1]));
      max_z_r         <= 32'(bba_pkg::SUM_W'(high_a[2]));
      out_box_valid_r <= box_valid_r;
      longest_r       <= longest;
      shortest_r      <= shortest;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_box_min_x     = min_x_r;
  assign out_box_min_y     = min_y_r;
  assign out_box_min_z     = min_z_r;
  assign out_box_max_x     = max_x_r;
  assign out_box_max_y     = max_y_r;
  assign out_box_max_z     = max_z_r;
  assign out_box_valid     = out_box_valid_r;
  assign out_longest_axis  = longest_r;
  assign out_shortest_axis = shortest_r;

endmodule
